// ----- design/m5jr_pkg.sv -----
// Shared constants for the median-of-five jump-reject filter.
`default_nettype none
package m5jr_pkg;

  // Converter word width (default for the top-level parameter)
  localparam int unsigned SAMPLE_BITS = 24;
  // Jump limit register width and reset value
  localparam int unsigned JUMP_BITS   = 24;
  localparam logic [JUMP_BITS-1:0] JUMP_RESET = JUMP_BITS'(150000);
  // Samples per group, and how many of them are held in the cell chain
  localparam int unsigned GROUP_LEN   = 5;
  localparam int unsigned STORE_DEPTH = GROUP_LEN - 1;
  localparam int unsigned CNT_W       = 3;

endpackage
`default_nettype wire

// ----- design/m5jr_in_if.sv -----
// Input channel: one converter word or timeout flag per transaction.
`default_nettype none
interface m5jr_in_if
  import m5jr_pkg::*;
#(
  parameter int unsigned SampleBits = SAMPLE_BITS
);
  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] raw_word;
  logic                  timed_out;

  modport source (output valid, output raw_word, output timed_out, input ready);
  modport sink   (input valid, input raw_word, input timed_out, output ready);
endinterface
`default_nettype wire

// ----- design/m5jr_out_if.sv -----
// Output channel: one filtered value per transaction.
`default_nettype none
interface m5jr_out_if
  import m5jr_pkg::*;
#(
  parameter int unsigned SampleBits = SAMPLE_BITS
);
  logic                      valid;
  logic                      ready;
  logic signed [SampleBits:0] filtered_value;

  modport source (output valid, output filtered_value, input ready);
  modport sink   (input valid, input filtered_value, output ready);
endinterface
`default_nettype wire

// ----- design/m5jr_cfg_if.sv -----
// Configuration write channel carrying the jump limit.
`default_nettype none
interface m5jr_cfg_if
  import m5jr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [JUMP_BITS-1:0] jump_limit;

  modport source (output valid, output jump_limit, input ready);
  modport sink   (input valid, input jump_limit, output ready);
endinterface
`default_nettype wire

// ----- design/m5jr_cell.sv -----
// One sample cell of the holding chain: loads from its neighbor on shift.
`default_nettype none
module m5jr_cell
  import m5jr_pkg::*;
#(
  parameter int unsigned SampleBits = SAMPLE_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      shift_i,
  input  wire logic signed [SampleBits:0] d_i,
  output logic signed [SampleBits:0]      q_o
);

  logic signed [SampleBits:0] smp_q;

  // Take the neighbor's sample on every shift
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      smp_q <= d_i;
    end
  end

  assign q_o = smp_q;

endmodule
`default_nettype wire

// ----- design/m5jr_median.sv -----
// Rank-based median of five signed samples.
`default_nettype none
module m5jr_median
  import m5jr_pkg::*;
#(
  parameter int unsigned SampleBits = SAMPLE_BITS
) (
  input  wire logic signed [SampleBits:0] smp_i [GROUP_LEN],
  output logic signed [SampleBits:0]      med_o
);

  logic [GROUP_LEN-1:0] lt [GROUP_LEN];
  logic [2:0]           n_lt [GROUP_LEN];
  logic [2:0]           n_le [GROUP_LEN];
  logic [GROUP_LEN-1:0] hit;

  // Compare every pair in parallel
  always_comb begin
    for (int i = 0; i < GROUP_LEN; i++) begin
      for (int j = 0; j < GROUP_LEN; j++) begin
        lt[i][j] = smp_i[i] < smp_i[j];
      end
    end
  end

  // Count, for each sample, how many others lie below it or at most equal
  always_comb begin
    for (int i = 0; i < GROUP_LEN; i++) begin
      n_lt[i] = '0;
      n_le[i] = '0;
      for (int j = 0; j < GROUP_LEN; j++) begin
        if (j != i) begin
          n_lt[i] = n_lt[i] + 3'(lt[j][i]);
          n_le[i] = n_le[i] + 3'(!lt[i][j]);
        end
      end
      // Middle rank: fewer than three below, at least two others not above
      hit[i] = (n_lt[i] <= 3'd2) && (n_le[i] >= 3'd2);
    end
  end

  // Pick the first sample that holds the middle rank
  always_comb begin
    med_o = smp_i[0];
    for (int i = GROUP_LEN - 1; i >= 0; i--) begin
      if (hit[i]) begin
        med_o = smp_i[i];
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/median5_jump_reject_filter.sv -----
// Median-of-five load-cell filter with jump rejection: top level.
//
// Usage:
//   in_i   : one transaction per conversion, raw_word (two's complement) or
//            timed_out, which turns the sample into the -2^SampleBits sentinel.
//   out_o  : one transaction per group of five inputs, the median of the
//            group, or the previous output if the median jumped by more than
//            jump_limit from a nonzero previous output.
//   cfg_i  : writes jump_limit; always ready. Write only while idle.
// Throughput: one input transaction per cycle while in_i.ready is high. The
//   first four samples of a group shift through a four-cell chain; the fifth
//   captures the group. After the fifth input is taken, the result passes the
//   group register, the median register, then the output register with the
//   jump check in front of it.
// Reset: clears the group count, previous output and pipeline valids, and
//   loads jump_limit with 150000.
// Stall: a held result backs up the median and group stages; inputs keep
//   flowing until a fifth sample finds the group stage still occupied.
`default_nettype none
module median5_jump_reject_filter
  import m5jr_pkg::*;
#(
  parameter int unsigned SampleBits = SAMPLE_BITS
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  m5jr_in_if.sink     in_i,
  m5jr_out_if.source  out_o,
  m5jr_cfg_if.sink    cfg_i
);

  localparam int unsigned SW    = SampleBits + 1;
  localparam int unsigned DW    = SampleBits + 2;
  localparam int unsigned CMP_W = (DW > JUMP_BITS) ? DW : JUMP_BITS;

  logic [JUMP_BITS-1:0] jump_limit_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic signed [SW-1:0] smp;
  logic signed [SW-1:0] chain [STORE_DEPTH+1];
  logic signed [SW-1:0] grp_q [GROUP_LEN];
  logic signed [SW-1:0] med, med_q, prev_q, res;
  logic grp_vld_q, med_vld_q, out_vld_q;
  logic in_acc, fifth, shift;
  logic out_free, med_adv, med_free, grp_adv, grp_free;
  logic signed [DW-1:0] diff;
  logic [DW-1:0]        diff_abs;
  logic                 keep_prev;

  // Configuration register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_limit_q <= JUMP_RESET;
    end else if (cfg_i.valid) begin
      jump_limit_q <= cfg_i.jump_limit;
    end
  end

  // Form the sample: sentinel on timeout, else sign-extend
  always_comb begin
    if (in_i.timed_out) begin
      smp = {1'b1, {SampleBits{1'b0}}};
    end else begin
      smp = {in_i.raw_word[SampleBits-1], in_i.raw_word};
    end
  end

  // Stage handshake: each stage advances when the next one frees up
  assign out_free = !out_vld_q || out_o.ready;
  assign med_adv  = med_vld_q && out_free;
  assign med_free = !med_vld_q || med_adv;
  assign grp_adv  = grp_vld_q && med_free;
  assign grp_free = !grp_vld_q || grp_adv;

  assign fifth      = (cnt_q >= CNT_W'(STORE_DEPTH));
  assign in_i.ready = !fifth || grp_free;
  assign in_acc     = in_i.valid && in_i.ready;
  assign shift      = in_acc && !fifth;
  assign cnt_d      = fifth ? '0 : cnt_q + 1'b1;

  // Group count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc) begin
      cnt_q <= cnt_d;
    end
  end

  // Hold the first four samples of a group in a shifting chain of cells
  assign chain[0] = smp;
  for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
    m5jr_cell #(
      .SampleBits(SampleBits)
    ) u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .d_i    (chain[k]),
      .q_o    (chain[k+1])
    );
  end

  // Capture the whole group on the fifth sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_vld_q <= 1'b0;
    end else if (in_acc && fifth) begin
      grp_vld_q <= 1'b1;
    end else if (grp_adv) begin
      grp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && fifth) begin
      grp_q[0] <= smp;
      for (int k = 1; k < GROUP_LEN; k++) begin
        grp_q[k] <= chain[k];
      end
    end
  end

  m5jr_median #(
    .SampleBits(SampleBits)
  ) u_median (
    .smp_i(grp_q),
    .med_o(med)
  );

  // Median register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      med_vld_q <= 1'b0;
    end else if (grp_adv) begin
      med_vld_q <= 1'b1;
    end else if (med_adv) begin
      med_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_adv) begin
      med_q <= med;
    end
  end

  // Jump check against the previous output in wide arithmetic
  assign diff      = DW'(med_q) - DW'(prev_q);
  assign diff_abs  = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign keep_prev = (prev_q != '0) &&
                     (CMP_W'(diff_abs) > CMP_W'(jump_limit_q));
  assign res       = keep_prev ? prev_q : med_q;

  // Output register and previous output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      prev_q    <= '0;
    end else begin
      if (med_adv) begin
        out_vld_q <= 1'b1;
        prev_q    <= res;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.filtered_value = prev_q;

  // The group count never passes the fifth sample
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(STORE_DEPTH))
    else $error("group count out of range");

  // A fifth sample always fills the group stage
  a_grp_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && fifth) |=> grp_vld_q)
    else $error("group not captured");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |=> (out_vld_q && $stable(prev_q)))
    else $error("stalled result changed");

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the median-of-five jump-reject filter.
`default_nettype none
module tb;
  import m5jr_pkg::*;

  typedef logic signed [SAMPLE_BITS:0] sample_t;

  localparam sample_t SENTINEL = {1'b1, {SAMPLE_BITS{1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] WORD_MAX_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] WORD_MIN_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] WORD_ALL_ONES = {SAMPLE_BITS{1'b1}};
  localparam logic [JUMP_BITS-1:0] LIMIT_MAX = {JUMP_BITS{1'b1}};
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int GROUPS_PER_PHASE = 60;

  logic clk;
  logic rst_n;

  m5jr_in_if  in_ch ();
  m5jr_out_if out_ch ();
  m5jr_cfg_if cfg_ch ();

  median5_jump_reject_filter u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Filter state mirrored on the testbench side
  logic [JUMP_BITS-1:0] model_limit;
  sample_t              held_samples [STORE_DEPTH];
  int                   held_count;
  sample_t              last_output;
  sample_t              pending_medians [$];

  int send_idle_pct;
  int recv_stall_pct;
  int failures;
  int samples_sent;
  int medians_checked;
  int holds_predicted;
  int sentinel_wins;
  int limits_written;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Advance the mirrored filter by one accepted sample; queue a median on group end
  task automatic advance_filter(input logic [SAMPLE_BITS-1:0] word, input logic tout);
    sample_t s;
    sample_t m;
    sample_t grp [GROUP_LEN];
    int      n_lt;
    int      n_le;
    longint  gap;
    s = tout ? SENTINEL : sample_t'({word[SAMPLE_BITS-1], word});
    if (held_count < STORE_DEPTH) begin
      held_samples[held_count] = s;
      held_count++;
    end else begin
      held_count = 0;
      for (int i = 0; i < STORE_DEPTH; i++) grp[i] = held_samples[i];
      grp[STORE_DEPTH] = s;
      m = grp[0];
      // Median: the value with at most two below it and at least three at or below
      for (int i = 0; i < GROUP_LEN; i++) begin
        n_lt = 0;
        n_le = 0;
        for (int j = 0; j < GROUP_LEN; j++) begin
          if (grp[j] < grp[i]) n_lt++;
          if (grp[j] <= grp[i]) n_le++;
        end
        if (n_lt <= 2 && n_le >= 3) m = grp[i];
      end
      // Hold the previous output on a jump; a zero previous output disables the check
      if (last_output != 0) begin
        gap = longint'(m) - longint'(last_output);
        if (gap < 0) gap = -gap;
        if (gap > longint'(model_limit)) begin
          m = last_output;
          holds_predicted++;
        end
      end
      if (m == SENTINEL) sentinel_wins++;
      last_output = m;
      pending_medians.push_back(m);
    end
  endtask

  // Offer one sample, idling first at random, and advance the model on acceptance
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] word, input logic tout);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.raw_word  <= word;
    in_ch.timed_out <= tout;
    do @(posedge clk); while (!in_ch.ready);
    advance_filter(word, tout);
    samples_sent++;
  endtask

  // Drop valid and wait until every queued median has been seen
  task automatic settle_filter();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_jump_limit(input logic [JUMP_BITS-1:0] value);
    settle_filter();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.jump_limit <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    model_limit = value;
    limits_written++;
  endtask

  // Send a sample near the center most of the time, else noise, extremes or timeouts
  task automatic send_random_sample(input longint center, input longint spread);
    int unsigned pick;
    longint      v;
    logic [SAMPLE_BITS-1:0] word;
    logic        tout;
    pick = $urandom_range(99);
    tout = 1'b0;
    word = SAMPLE_BITS'($urandom);
    if (pick < 8) begin
      tout = 1'b1;
    end else if (pick < 16) begin
      word = SAMPLE_BITS'($urandom);
    end else if (pick < 20) begin
      case ($urandom_range(3))
        0: word = '0;
        1: word = WORD_MAX_POS;
        2: word = WORD_MIN_NEG;
        default: word = WORD_ALL_ONES;
      endcase
    end else if (pick < 30) begin
      word = SAMPLE_BITS'(center);
    end else begin
      v = center + longint'($urandom_range(32'(2 * spread))) - spread;
      if (v > longint'(WORD_MAX_POS)) v = longint'(WORD_MAX_POS);
      if (v < -(longint'(1) << (SAMPLE_BITS - 1))) v = -(longint'(1) << (SAMPLE_BITS - 1));
      word = SAMPLE_BITS'(v);
    end
    send_sample(word, tout);
  endtask

  // Check each output transaction against the oldest queued median; stall at random
  always @(posedge clk) begin : check_output
    sample_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_medians.size() == 0) begin
        $display("%0t: unexpected filtered_value, expected none, actual %0d",
                 $time, out_ch.filtered_value);
        failures++;
      end else begin
        want = pending_medians.pop_front();
        medians_checked++;
        if (out_ch.filtered_value !== want) begin
          $display("%0t: filtered_value mismatch, expected %0d, actual %0d",
                   $time, want, out_ch.filtered_value);
          failures++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d medians outstanding",
               $time, idle_cycles, pending_medians.size());
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset limit: zero median with check off, sentinel win, held sentinel on a big jump
  task automatic test_reset_limit_groups();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_sample('0, 1'b0);
    send_sample('0, 1'b0);
    send_sample('0, 1'b0);
    send_sample(WORD_MAX_POS, 1'b0);
    send_sample(WORD_MIN_NEG, 1'b0);
    // Timeouts carry data that must be ignored
    send_sample(WORD_ALL_ONES, 1'b1);
    send_sample('0, 1'b1);
    send_sample(SAMPLE_BITS'(24'h123456), 1'b1);
    send_sample(WORD_MAX_POS, 1'b0);
    send_sample(WORD_ALL_ONES, 1'b0);
    repeat (GROUP_LEN) send_sample(WORD_MAX_POS, 1'b0);
  endtask

  // Largest limit: a jump of exactly the limit passes; zero limit: any change holds
  task automatic test_limit_extremes();
    write_jump_limit(LIMIT_MAX);
    repeat (GROUP_LEN) send_sample(WORD_ALL_ONES, 1'b0);
    write_jump_limit('0);
    repeat (GROUP_LEN) send_sample(SAMPLE_BITS'(1), 1'b0);
  endtask

  // Random groups clustered around the last output, under one limit and idling mode
  task automatic test_random_traffic(input logic [JUMP_BITS-1:0] limit,
                                     input int send_pct, input int recv_pct);
    longint center;
    longint spread;
    write_jump_limit(limit);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    spread = (longint'(limit) < 64) ? 64 : 2 * longint'(limit);
    if (spread > longint'(LIMIT_MAX)) spread = longint'(LIMIT_MAX);
    repeat (GROUPS_PER_PHASE) begin
      if (last_output != SENTINEL && $urandom_range(9) != 0)
        center = longint'(last_output);
      else
        center = longint'($signed(SAMPLE_BITS'($urandom)));
      repeat (GROUP_LEN) send_random_sample(center, spread);
    end
    settle_filter();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.raw_word    = '0;
    in_ch.timed_out   = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.jump_limit = '0;
    out_ch.ready      = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    failures          = 0;
    samples_sent      = 0;
    medians_checked   = 0;
    holds_predicted   = 0;
    sentinel_wins     = 0;
    limits_written    = 0;
    idle_cycles       = 0;
    model_limit       = JUMP_RESET;
    held_count        = 0;
    last_output       = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_limit_groups();
    test_limit_extremes();
    test_random_traffic(JUMP_RESET, 0, 0);
    test_random_traffic(JUMP_BITS'($urandom_range(400000, 1000)), 75, 0);
    test_random_traffic('0, 0, 75);
    test_random_traffic(LIMIT_MAX, 11, 11);
    settle_filter();

    $display("Sent %0d samples, checked %0d medians (%0d held on a jump, %0d sentinel).",
             samples_sent, medians_checked, holds_predicted, sentinel_wins);
    $display("Jump limit written %0d times; %0d mismatches.", limits_written, failures);
    if (failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
